// ----- src/hdpm_pkg.sv -----
package hdpm_pkg;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_ROWS    = 1'b0;
  localparam logic REG_COLUMNS = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [3:0] row_index;
    logic [3:0] column_index;
    logic [3:0] query_row;
    logic [3:0] query_column;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } be_stat_t;

  typedef struct packed {
    logic [3:0]  peak_row;
    logic [3:0]  peak_column;
    logic [3:0]  highest_row;
    logic [3:0]  highest_column;
    logic [3:0]  row_median;
    logic        row_median_none;
    logic [3:0]  column_median;
    logic        column_median_none;
    logic [31:0] total_count;
  } res_t;

endpackage

// ----- src/two_d_histogram_peak_median_top.sv -----
// Channel   Ports                      Transfer
// input     in_valid / in_ready        one add or query request per handshake
// output    out_valid / out_ready      one result per query request
// config    psel/penable/pwrite/paddr  APB write/read, pready tied high
//
// Add: dispatch, bin read, bin write back.
// Query: four scans through the RAM read port, one bin per cycle;
// a median scan whose index lies outside the area is skipped.
// After reset every bin of the RAM is cleared; in_ready stays low until then.
// A two-entry queue decouples intake from execution; a waiting result stalls
// only the back end, and only once the next result is ready.
module two_d_histogram_peak_median_top #(
  parameter int MAX_ROWS    = 16,
  parameter int MAX_COLUMNS = 16,
  parameter int BIN_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [3:0]  in_row_index,
  input  logic [3:0]  in_column_index,
  input  logic [3:0]  in_query_row,
  input  logic [3:0]  in_query_column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_peak_row,
  output logic [3:0]  out_peak_column,
  output logic [3:0]  out_highest_row,
  output logic [3:0]  out_highest_column,
  output logic [3:0]  out_row_median,
  output logic        out_row_median_none,
  output logic [3:0]  out_column_median,
  output logic        out_column_median_none,
  output logic [31:0] out_total_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hdpm_pkg::*;

  localparam logic [4:0] ROWS_RST = 5'((MAX_ROWS < 16) ? MAX_ROWS : 16);
  localparam logic [4:0] COLS_RST = 5'((MAX_COLUMNS < 16) ? MAX_COLUMNS : 16);

  logic [4:0] rows_r, rows_nxt, cols_r, cols_nxt;
  logic       wr_en;
  logic       q_valid, q_pop;
  cmd_t       q_cmd;
  be_stat_t   stat;
  res_t       res;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_COLUMNS) ? {27'd0, cols_r} : {27'd0, rows_r};

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (wr_en) begin
      if (paddr[2] == REG_ROWS) begin
        if (pwdata[4:0] == 5'd0) begin
          rows_nxt = 5'd1;
        end else if (32'(pwdata[4:0]) > MAX_ROWS) begin
          rows_nxt = 5'(MAX_ROWS);
        end else begin
          rows_nxt = pwdata[4:0];
        end
      end else begin
        if (pwdata[4:0] == 5'd0) begin
          cols_nxt = 5'd1;
        end else if (32'(pwdata[4:0]) > MAX_COLUMNS) begin
          cols_nxt = 5'(MAX_COLUMNS);
        end else begin
          cols_nxt = pwdata[4:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RST;
      cols_r <= COLS_RST;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  hdpm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_row_index   (in_row_index),
    .in_column_index(in_column_index),
    .in_query_row   (in_query_row),
    .in_query_column(in_query_column),
    .rows_in_use    (rows_r),
    .columns_in_use (cols_r),
    .stat           (stat),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop)
  );

  hdpm_back #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLUMNS(MAX_COLUMNS),
    .BIN_WIDTH  (BIN_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .rows_in_use   (rows_r),
    .columns_in_use(cols_r),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .stat          (stat),
    .res           (res),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

  assign out_peak_row           = res.peak_row;
  assign out_peak_column        = res.peak_column;
  assign out_highest_row        = res.highest_row;
  assign out_highest_column     = res.highest_column;
  assign out_row_median         = res.row_median;
  assign out_row_median_none    = res.row_median_none;
  assign out_column_median      = res.column_median;
  assign out_column_median_none = res.column_median_none;
  assign out_total_count        = res.total_count;

endmodule

// ----- src/hdpm_ram.sv -----
module hdpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/hdpm_front.sv -----
module hdpm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [3:0]        in_row_index,
  input  logic [3:0]        in_column_index,
  input  logic [3:0]        in_query_row,
  input  logic [3:0]        in_query_column,
  input  logic [4:0]        rows_in_use,
  input  logic [4:0]        columns_in_use,
  input  hdpm_pkg::be_stat_t stat,
  output logic              q_valid,
  output hdpm_pkg::cmd_t    q_cmd,
  input  logic              q_pop
);
  import hdpm_pkg::*;

  cmd_t       q_mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept, push, in_range;
  cmd_t       cmd_in;

  assign in_ready = !stat.clearing && (cnt_r != 2'd2);
  assign accept   = in_valid && in_ready;
  assign in_range = (5'(in_row_index) < rows_in_use) && (5'(in_column_index) < columns_in_use);
  // drop adds that fall outside the area in use
  assign push     = accept && ((in_operation == OP_QUERY) || in_range);

  assign cmd_in.operation    = in_operation;
  assign cmd_in.row_index    = in_row_index;
  assign cmd_in.column_index = in_column_index;
  assign cmd_in.query_row    = in_query_row;
  assign cmd_in.query_column = in_query_column;

  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = q_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_mem_r[wp_r] <= cmd_in;
    end
  end

endmodule

// ----- src/hdpm_back.sv -----
module hdpm_back #(
  parameter int MAX_ROWS    = 16,
  parameter int MAX_COLUMNS = 16,
  parameter int BIN_WIDTH   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [4:0]         rows_in_use,
  input  logic [4:0]         columns_in_use,
  input  logic               q_valid,
  input  hdpm_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output hdpm_pkg::be_stat_t stat,
  output hdpm_pkg::res_t     res,
  output logic               out_valid,
  input  logic               out_ready
);
  import hdpm_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLUMNS + 1);
  localparam int SW    = BIN_WIDTH + $clog2(DEPTH + 1);

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_ADD_RD, ST_ADD_WR, ST_SCAN, ST_DONE} state_t;
  typedef enum logic [1:0] {P_ROWS, P_COLS, P_RMED, P_CMED} pass_t;

  state_t               state_r, state_nxt;
  pass_t                pass_r, pass_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [RCW-1:0]       ar_r, ar_nxt, tr_r, tr_nxt, peak_row_r, peak_row_nxt;
  logic [RCW-1:0]       best_row_r, best_row_nxt, cmed_r, cmed_nxt;
  logic [CCW-1:0]       ac_r, ac_nxt, tc_r, tc_nxt, peak_col_r, peak_col_nxt;
  logic [CCW-1:0]       best_col_r, best_col_nxt, rmed_r, rmed_nxt;
  logic                 iss_r, iss_nxt, tv_r, tv_nxt, teol_r, teol_nxt, tlast_r, tlast_nxt;
  logic                 rnone_r, rnone_nxt, cnone_r, cnone_nxt, ov_r, ov_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [31:0]          total_r, total_nxt;
  logic [BIN_WIDTH-1:0] peak_v_r, peak_v_nxt;
  logic [SW-1:0]        acc_r, acc_nxt, brs_r, brs_nxt, bcs_r, bcs_nxt;
  logic [SW-1:0]        qrs_r, qrs_nxt, qcs_r, qcs_nxt, sum, thr;
  res_t                 res_r, res_nxt;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [BIN_WIDTH-1:0] wdata, rdata;
  logic                 r_last, c_last, eol, last, qr_ok, qc_ok;

  hdpm_ram #(.WIDTH(BIN_WIDTH), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  function automatic logic [AW-1:0] bin_addr(input logic [31:0] r, input logic [31:0] c);
    bin_addr = AW'(r * MAX_COLUMNS + c);
  endfunction

  assign qr_ok  = 5'(cmd_r.query_row) < rows_in_use;
  assign qc_ok  = 5'(cmd_r.query_column) < columns_in_use;
  assign r_last = ar_r == RCW'(rows_in_use - 5'd1);
  assign c_last = ac_r == CCW'(columns_in_use - 5'd1);
  assign sum    = acc_r + SW'(rdata);

  assign stat.clearing = (state_r == ST_CLEAR);
  assign res           = res_r;
  assign out_valid     = ov_r;

  always_comb begin
    state_nxt    = state_r;
    pass_nxt     = pass_r;
    clr_nxt      = clr_r;
    ar_nxt       = ar_r;
    ac_nxt       = ac_r;
    iss_nxt      = iss_r;
    tv_nxt       = 1'b0;
    tr_nxt       = ar_r;
    tc_nxt       = ac_r;
    teol_nxt     = 1'b0;
    tlast_nxt    = 1'b0;
    cmd_nxt      = cmd_r;
    total_nxt    = total_r;
    peak_v_nxt   = peak_v_r;
    peak_row_nxt = peak_row_r;
    peak_col_nxt = peak_col_r;
    acc_nxt      = acc_r;
    brs_nxt      = brs_r;
    bcs_nxt      = bcs_r;
    best_row_nxt = best_row_r;
    best_col_nxt = best_col_r;
    qrs_nxt      = qrs_r;
    qcs_nxt      = qcs_r;
    rmed_nxt     = rmed_r;
    rnone_nxt    = rnone_r;
    cmed_nxt     = cmed_r;
    cnone_nxt    = cnone_r;
    res_nxt      = res_r;
    ov_nxt       = ov_r && !out_ready;
    q_pop        = 1'b0;
    we           = 1'b0;
    waddr        = bin_addr(32'(cmd_r.row_index), 32'(cmd_r.column_index));
    wdata        = (&rdata) ? rdata : rdata + BIN_WIDTH'(1);
    raddr        = bin_addr(32'(ar_r), 32'(ac_r));
    eol          = 1'b0;
    last         = 1'b0;
    thr          = '0;

    case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.operation == OP_ADD) begin
            state_nxt = ST_ADD_RD;
          end else begin
            state_nxt  = ST_SCAN;
            pass_nxt   = P_ROWS;
            ar_nxt     = '0;
            ac_nxt     = '0;
            iss_nxt    = 1'b1;
            peak_v_nxt = '0;
            peak_row_nxt = '0;
            peak_col_nxt = '0;
            acc_nxt    = '0;
            brs_nxt    = '0;
            bcs_nxt    = '0;
            best_row_nxt = '0;
            best_col_nxt = '0;
            qrs_nxt    = '0;
            qcs_nxt    = '0;
            rmed_nxt   = '0;
            rnone_nxt  = 1'b1;
            cmed_nxt   = '0;
            cnone_nxt  = 1'b1;
          end
        end
      end
      ST_ADD_RD: begin
        raddr     = bin_addr(32'(cmd_r.row_index), 32'(cmd_r.column_index));
        state_nxt = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        we = 1'b1;
        if (total_r != 32'hFFFF_FFFF) begin
          total_nxt = total_r + 32'd1;
        end
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        // issue side: walk addresses of the current pass
        case (pass_r)
          P_ROWS: begin
            eol  = c_last;
            last = c_last && r_last;
            if (c_last) begin
              ac_nxt = '0;
              ar_nxt = ar_r + RCW'(1);
            end else begin
              ac_nxt = ac_r + CCW'(1);
            end
          end
          P_COLS: begin
            eol  = r_last;
            last = r_last && c_last;
            if (r_last) begin
              ar_nxt = '0;
              ac_nxt = ac_r + CCW'(1);
            end else begin
              ar_nxt = ar_r + RCW'(1);
            end
          end
          P_RMED: begin
            eol    = c_last;
            last   = c_last;
            ac_nxt = ac_r + CCW'(1);
          end
          P_CMED: begin
            eol    = r_last;
            last   = r_last;
            ar_nxt = ar_r + RCW'(1);
          end
          default: ;
        endcase
        if (iss_r) begin
          tv_nxt    = 1'b1;
          teol_nxt  = eol;
          tlast_nxt = last;
          if (last) begin
            iss_nxt = 1'b0;
          end
        end else begin
          ar_nxt = ar_r;
          ac_nxt = ac_r;
        end

        // consume side: data for the address issued in the previous cycle
        if (tv_r) begin
          acc_nxt = teol_r ? '0 : sum;
          case (pass_r)
            P_ROWS: begin
              if (rdata > peak_v_r) begin
                peak_v_nxt   = rdata;
                peak_row_nxt = tr_r;
                peak_col_nxt = tc_r;
              end
              if (teol_r && (sum > brs_r)) begin
                brs_nxt      = sum;
                best_row_nxt = tr_r;
              end
              if (qr_ok && (tr_r == RCW'(cmd_r.query_row))) begin
                qrs_nxt = qrs_r + SW'(rdata);
              end
              if (qc_ok && (tc_r == CCW'(cmd_r.query_column))) begin
                qcs_nxt = qcs_r + SW'(rdata);
              end
            end
            P_COLS: begin
              if (teol_r && (sum > bcs_r)) begin
                bcs_nxt      = sum;
                best_col_nxt = tc_r;
              end
            end
            P_RMED: begin
              thr = SW'((SW + 1)'(qrs_r) + (SW + 1)'(1) >> 1);
              if (rnone_r && (thr != '0) && (sum >= thr)) begin
                rmed_nxt  = tc_r;
                rnone_nxt = 1'b0;
              end
            end
            P_CMED: begin
              thr = qcs_r >> 1;
              if (cnone_r && (thr != '0) && (sum >= thr)) begin
                cmed_nxt  = tr_r;
                cnone_nxt = 1'b0;
              end
            end
            default: ;
          endcase
          if (tlast_r) begin
            iss_nxt = 1'b1;
            if ((pass_r == P_ROWS)) begin
              pass_nxt = P_COLS;
              ar_nxt   = '0;
              ac_nxt   = '0;
            end else if ((pass_r == P_COLS) && qr_ok) begin
              pass_nxt = P_RMED;
              ar_nxt   = RCW'(cmd_r.query_row);
              ac_nxt   = '0;
            end else if ((pass_r != P_CMED) && qc_ok) begin
              pass_nxt = P_CMED;
              ar_nxt   = '0;
              ac_nxt   = CCW'(cmd_r.query_column);
            end else begin
              iss_nxt   = 1'b0;
              state_nxt = ST_DONE;
            end
          end
        end
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          res_nxt.peak_row           = 4'(peak_row_r);
          res_nxt.peak_column        = 4'(peak_col_r);
          res_nxt.highest_row        = 4'(best_row_r);
          res_nxt.highest_column     = 4'(best_col_r);
          res_nxt.row_median         = 4'(rmed_r);
          res_nxt.row_median_none    = rnone_r;
          res_nxt.column_median      = 4'(cmed_r);
          res_nxt.column_median_none = cnone_r;
          res_nxt.total_count        = total_r;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      pass_r  <= P_ROWS;
      clr_r   <= '0;
      iss_r   <= 1'b0;
      tv_r    <= 1'b0;
      ov_r    <= 1'b0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      clr_r   <= clr_nxt;
      iss_r   <= iss_nxt;
      tv_r    <= tv_nxt;
      ov_r    <= ov_nxt;
      total_r <= total_nxt;
    end
    ar_r       <= ar_nxt;
    ac_r       <= ac_nxt;
    tr_r       <= tr_nxt;
    tc_r       <= tc_nxt;
    teol_r     <= teol_nxt;
    tlast_r    <= tlast_nxt;
    cmd_r      <= cmd_nxt;
    peak_v_r   <= peak_v_nxt;
    peak_row_r <= peak_row_nxt;
    peak_col_r <= peak_col_nxt;
    acc_r      <= acc_nxt;
    brs_r      <= brs_nxt;
    bcs_r      <= bcs_nxt;
    best_row_r <= best_row_nxt;
    best_col_r <= best_col_nxt;
    qrs_r      <= qrs_nxt;
    qcs_r      <= qcs_nxt;
    rmed_r     <= rmed_nxt;
    rnone_r    <= rnone_nxt;
    cmed_r     <= cmed_nxt;
    cnone_r    <= cnone_nxt;
    res_r      <= res_nxt;
  end

endmodule

// ----- src/hdpm_checker.sv -----
module hdpm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_row_median,
  input logic        out_row_median_none,
  input logic [3:0]  out_column_median,
  input logic        out_column_median_none,
  input logic [31:0] out_total_count,
  input logic        pready
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_total_count))
    else $error("result changed while stalled");

  // bin RAM clear blocks intake right after reset
  a_clear_blocks: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("request taken during clear");

  a_row_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_median_none |-> out_row_median == 4'd0)
    else $error("row median set with none flag");

  a_col_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_column_median_none |-> out_column_median == 4'd0)
    else $error("column median set with none flag");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind two_d_histogram_peak_median_top hdpm_checker u_hdpm_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_ready              (in_ready),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_row_median        (out_row_median),
  .out_row_median_none   (out_row_median_none),
  .out_column_median     (out_column_median),
  .out_column_median_none(out_column_median_none),
  .out_total_count       (out_total_count),
  .pready                (pready)
);
